>>> hdl/sdd_pkg.sv
// Shared types and constants for the signed value to display digit converter.
// Used by sdd_ctrl, sdd_dp and signed_value_to_display_digits. No dependencies.
package sdd_pkg;

  localparam int ValWidth   = 15;
  localparam int MagWidth   = ValWidth - 1;
  localparam int DigitWidth = 4;
  localparam int NumDigits  = 4;
  localparam int BcdWidth   = DigitWidth * NumDigits;
  localparam int CntWidth   = $clog2(MagWidth + 1);

  localparam logic signed [ValWidth-1:0] ValMax = 15'sd9999;
  localparam logic signed [ValWidth-1:0] ValMin = -15'sd9999;

  localparam logic [DigitWidth-1:0] SymZero  = 4'd0;
  localparam logic [DigitWidth-1:0] SymBlank = 4'd10;
  localparam logic [DigitWidth-1:0] SymMinus = 4'd11;
  localparam logic [DigitWidth-1:0] DabbleMin = 4'd5;
  localparam logic [DigitWidth-1:0] DabbleAdd = 4'd3;

  typedef struct packed {
    logic signed [ValWidth-1:0] signed_value;
    logic                       temperature_mode;
    logic                       row_select;
  } in_t;

  typedef struct packed {
    logic [DigitWidth-1:0] sym_hundreds;
    logic [DigitWidth-1:0] sym_tens;
    logic [DigitWidth-1:0] sym_ones;
    logic [DigitWidth-1:0] sym_tenths;
    logic                  point_on_ones;
    logic                  row_out;
  } out_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic store;
  } ctrl_cmd_t;

  typedef struct packed {
    logic conv_done;
  } dp_stat_t;

endpackage

>>> hdl/sdd_ctrl.sv
// Sequencer for the converter: accept, shift-add conversion, result hand-off.
// Depends on sdd_pkg; drives sdd_dp through ctrl_cmd_t.
module sdd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output sdd_pkg::ctrl_cmd_t cmd,
  input  sdd_pkg::dp_stat_t  stat
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StConv = 2'd1;
  localparam logic [1:0] StFin  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      StIdle: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = StConv;
        end
      end
      StConv: begin
        if (stat.conv_done) begin
          state_nxt = StFin;
        end else begin
          cmd.shift = 1'b1;
        end
      end
      StFin: begin
        if (!out_valid_r || out_ready) begin
          cmd.store     = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = StIdle;
        end
      end
      default: begin
        state_nxt = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= StIdle;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> hdl/sdd_dp.sv
// Datapath: saturation, magnitude, double-dabble BCD shifter, symbol mapping
// and result register. Depends on sdd_pkg; commanded by sdd_ctrl.
module sdd_dp (
  input  logic               clk,
  input  logic               rst_n,
  input  sdd_pkg::in_t       in_data,
  input  sdd_pkg::ctrl_cmd_t cmd,
  output sdd_pkg::dp_stat_t  stat,
  output sdd_pkg::out_t      out_data
);

  localparam int DW = sdd_pkg::DigitWidth;

  logic [sdd_pkg::MagWidth-1:0] bin_r, bin_nxt;
  logic [sdd_pkg::BcdWidth-1:0] bcd_r, bcd_nxt, bcd_adj;
  logic [sdd_pkg::CntWidth-1:0] cnt_r, cnt_nxt;
  logic                         neg_r, dec_r, row_r;
  sdd_pkg::out_t                out_r, res;

  logic signed [sdd_pkg::ValWidth-1:0] sat_v;
  logic signed [sdd_pkg::ValWidth-1:0] neg_v;
  logic [sdd_pkg::MagWidth-1:0]        mag;

  logic [DW-1:0] b3, b2, b1, b0, d3, d2, d1, d0, s3, s2, s1;
  logic          big, dec;

  // saturate and take magnitude
  always_comb begin
    sat_v = in_data.signed_value;
    if (in_data.signed_value > sdd_pkg::ValMax) begin
      sat_v = sdd_pkg::ValMax;
    end else if (in_data.signed_value < sdd_pkg::ValMin) begin
      sat_v = sdd_pkg::ValMin;
    end
    neg_v = -sat_v;
    mag   = sat_v[sdd_pkg::ValWidth-1] ? neg_v[sdd_pkg::MagWidth-1:0]
                                       : sat_v[sdd_pkg::MagWidth-1:0];
  end

  // add-3 correction on each BCD nibble, then shift one bit in
  always_comb begin
    for (int i = 0; i < sdd_pkg::NumDigits; i++) begin
      if (bcd_r[i*DW +: DW] >= sdd_pkg::DabbleMin) begin
        bcd_adj[i*DW +: DW] = bcd_r[i*DW +: DW] + sdd_pkg::DabbleAdd;
      end else begin
        bcd_adj[i*DW +: DW] = bcd_r[i*DW +: DW];
      end
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    cnt_nxt = cnt_r;
    if (cmd.load) begin
      bin_nxt = mag;
      bcd_nxt = '0;
      cnt_nxt = '0;
    end else if (cmd.shift) begin
      bcd_nxt = {bcd_adj[sdd_pkg::BcdWidth-2:0], bin_r[sdd_pkg::MagWidth-1]};
      bin_nxt = {bin_r[sdd_pkg::MagWidth-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
    end
  end

  assign stat.conv_done = (cnt_r == sdd_pkg::CntWidth'(sdd_pkg::MagWidth));

  // symbol mapping
  always_comb begin
    b3  = bcd_r[3*DW +: DW];
    b2  = bcd_r[2*DW +: DW];
    b1  = bcd_r[1*DW +: DW];
    b0  = bcd_r[0 +: DW];
    // large negative: drop the last digit
    big = neg_r && (b3 != sdd_pkg::SymZero);
    if (big) begin
      d3 = sdd_pkg::SymZero;
      d2 = b3;
      d1 = b2;
      d0 = b1;
    end else begin
      d3 = b3;
      d2 = b2;
      d1 = b1;
      d0 = b0;
    end
    dec = dec_r && !big;

    s3 = (d3 != sdd_pkg::SymZero) ? d3 : sdd_pkg::SymBlank;
    if (d2 != sdd_pkg::SymZero) begin
      s2 = d2;
    end else begin
      s2 = (s3 != sdd_pkg::SymBlank) ? sdd_pkg::SymZero : sdd_pkg::SymBlank;
    end
    if (d1 != sdd_pkg::SymZero) begin
      s1 = d1;
    end else begin
      s1 = (s2 != sdd_pkg::SymBlank) ? sdd_pkg::SymZero : sdd_pkg::SymBlank;
    end
    if (dec && s1 == sdd_pkg::SymBlank) begin
      s1 = sdd_pkg::SymZero;
    end

    if (neg_r) begin
      if (d3 == sdd_pkg::SymZero && d2 == sdd_pkg::SymZero &&
          d1 == sdd_pkg::SymZero && !dec) begin
        s1 = sdd_pkg::SymMinus;
      end else if (d3 == sdd_pkg::SymZero && d2 == sdd_pkg::SymZero) begin
        s2 = sdd_pkg::SymMinus;
      end else if (d3 == sdd_pkg::SymZero) begin
        s3 = sdd_pkg::SymMinus;
      end
    end

    res.sym_hundreds  = s3;
    res.sym_tens      = s2;
    res.sym_ones      = s1;
    res.sym_tenths    = d0;
    res.point_on_ones = dec;
    res.row_out       = row_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    bcd_r <= bcd_nxt;
    if (cmd.load) begin
      neg_r <= sat_v[sdd_pkg::ValWidth-1];
      dec_r <= in_data.temperature_mode;
      row_r <= in_data.row_select;
    end
    if (cmd.store) begin
      out_r <= res;
    end
  end

  assign out_data = out_r;

endmodule

>>> hdl/signed_value_to_display_digits.sv
// Signed value to four display symbols, with leading blanking and sign.
// Inputs are taken only while idle, so a new beat waits until the previous one has
// finished the 14 shift steps of the double-dabble BCD converter and been stored.
// The next input beat is taken while a finished result waits on the output.
// Reset (rst_n low, synchronous) empties the sequencer and clears out_valid; out_data is not reset.
module signed_value_to_display_digits (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  sdd_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output sdd_pkg::out_t out_data
);

  sdd_pkg::ctrl_cmd_t cmd;
  sdd_pkg::dp_stat_t  stat;

  sdd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  sdd_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .stat     (stat),
    .out_data (out_data)
  );

  // busy right after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input taken twice in a row");

  // a lit point always sits on a numeral
  a_point_on_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.point_on_ones) |->
      (out_data.sym_ones != sdd_pkg::SymBlank && out_data.sym_ones != sdd_pkg::SymMinus))
    else $error("point on non-numeral");

  a_tenths_numeral: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.sym_tenths <= 4'd9))
    else $error("rightmost symbol not a numeral");

  // at most one minus sign
  a_one_minus: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0({out_data.sym_hundreds == sdd_pkg::SymMinus,
                            out_data.sym_tens == sdd_pkg::SymMinus,
                            out_data.sym_ones == sdd_pkg::SymMinus}))
    else $error("more than one minus sign");

endmodule
